FILE: src/sbfr_pkg.sv
// ----------------------------------------------------------------------------
// sbfr_pkg
// shared types and constants of the servo bus frame receiver
// ----------------------------------------------------------------------------
package sbfr_pkg;

   // payload storage and frame length limits
   localparam int MAX_PAYLOAD = 5;
   localparam int STORE_DEPTH = 5;
   localparam int PAY_CAP     = (MAX_PAYLOAD < STORE_DEPTH) ? MAX_PAYLOAD : STORE_DEPTH;
   localparam int LEN_CAP     = PAY_CAP + 2;
   localparam int MIN_LENGTH  = 3;

   // frame queue between the parser and the result sequencer
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration register indexes
   localparam int CSR_IDX_W       = 1;
   localparam int CSR_DATA_W      = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH  = 1'd1;

   // register reset values
   localparam logic [7:0] HEADER_RESET  = 8'h55;
   localparam logic [2:0] MAX_LEN_RESET = 3'd7;

   // frame status codes
   localparam logic STATUS_GOOD = 1'b0;
   localparam logic STATUS_BAD  = 1'b1;

   typedef logic [7:0] byte_type;

   // one parsed frame, handed from the parser to the sequencer
   typedef struct packed {
      byte_type [STORE_DEPTH-1:0] payload;
      logic [2:0]                 count;
      byte_type                   id;
      logic                       status;
   } frame_rec_type;

endpackage

FILE: src/sbfr_front.sv
// ----------------------------------------------------------------------------
// sbfr_front
// header hunt, frame field capture and running checksum
// ----------------------------------------------------------------------------
module sbfr_front
   import sbfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  byte_type              rx_byte,
   input  logic                  q_full,
   output logic                  push,
   output frame_rec_type         push_rec
);

   logic [2:0]                    max_len_ff, max_len_in;
   logic                          seen_ff, seen_in;
   logic                          in_frame_ff, in_frame_in;
   logic [3:0]                    pos_ff, pos_in;
   logic [2:0]                    len_ff, len_in;
   byte_type                      id_ff, id_in;
   byte_type                      sum_ff, sum_in;
   byte_type [STORE_DEPTH-1:0]    store_ff, store_in;
   byte_type                      header_byte_ff, header_byte_in;

   logic       accept;
   logic       at_end;
   logic [2:0] limit;
   logic [3:0] store_idx;
   logic       bad_sum;

   // checksum byte position reached
   assign at_end = in_frame_ff && (pos_ff >= 4'd4)
                   && ({1'b0, pos_ff} >= ({2'b00, len_ff} + 5'd2));
   assign req_tready = !(at_end && q_full);
   assign accept     = req_tvalid && req_tready;

   assign limit     = (max_len_ff < 3'(LEN_CAP)) ? max_len_ff : 3'(LEN_CAP);
   assign store_idx = pos_ff - 4'd4;
   assign bad_sum   = (~sum_ff) != rx_byte;

   // frame record towards the queue
   assign push             = accept && at_end;
   assign push_rec.payload = store_ff;
   assign push_rec.id      = id_ff;
   assign push_rec.status  = bad_sum ? STATUS_BAD : STATUS_GOOD;
   assign push_rec.count   = bad_sum ? 3'd1 : (len_ff - 3'd2);

   // configuration writes
   always_comb begin
      header_byte_in = header_byte_ff;
      max_len_in     = max_len_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HEADER_BYTE: header_byte_in = csr_wdata;
            CSR_MAX_LENGTH:  max_len_in     = csr_wdata[2:0];
            default:         ;
         endcase
      end
   end

   // byte parser
   always_comb begin
      seen_in     = seen_ff;
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      id_in       = id_ff;
      sum_in      = sum_ff;
      store_in    = store_ff;
      if (accept) begin
         if (!in_frame_ff) begin
            if (rx_byte == header_byte_ff) begin
               if (seen_ff) begin
                  seen_in     = 1'b0;
                  in_frame_in = 1'b1;
                  pos_in      = 4'd2;
                  sum_in      = '0;
               end else begin
                  seen_in = 1'b1;
               end
            end else begin
               seen_in = 1'b0;
            end
         end else if (pos_ff == 4'd2) begin
            id_in  = rx_byte;
            sum_in = sum_ff + rx_byte;
            pos_in = 4'd3;
         end else if (pos_ff == 4'd3) begin
            if ((rx_byte < 8'(MIN_LENGTH)) || (rx_byte > {5'b0, limit})) begin
               seen_in     = 1'b0;
               in_frame_in = 1'b0;
               pos_in      = '0;
               sum_in      = '0;
            end else begin
               len_in = rx_byte[2:0];
               sum_in = sum_ff + rx_byte;
               pos_in = 4'd4;
            end
         end else if (at_end) begin
            seen_in     = 1'b0;
            in_frame_in = 1'b0;
            pos_in      = '0;
            sum_in      = '0;
         end else begin
            if (store_idx < 4'(STORE_DEPTH)) begin
               store_in[store_idx[2:0]] = rx_byte;
            end
            sum_in = sum_ff + rx_byte;
            pos_in = pos_ff + 4'd1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         header_byte_ff <= HEADER_RESET;
         max_len_ff     <= MAX_LEN_RESET;
         seen_ff        <= 1'b0;
         in_frame_ff    <= 1'b0;
         pos_ff         <= '0;
         len_ff         <= 3'd2;
         id_ff          <= '0;
         sum_ff         <= '0;
      end else begin
         header_byte_ff <= header_byte_in;
         max_len_ff     <= max_len_in;
         seen_ff        <= seen_in;
         in_frame_ff    <= in_frame_in;
         pos_ff         <= pos_in;
         len_ff         <= len_in;
         id_ff          <= id_in;
         sum_ff         <= sum_in;
      end
   end

   // payload bytes of the current frame
   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

endmodule

FILE: src/sbfr_queue.sv
// ----------------------------------------------------------------------------
// sbfr_queue
// short queue of parsed frames between parser and sequencer
// ----------------------------------------------------------------------------
module sbfr_queue
   import sbfr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  frame_rec_type push_rec,
   input  logic          pop,
   output logic          full,
   output logic          not_empty,
   output frame_rec_type head
);

   frame_rec_type [QUEUE_DEPTH-1:0] entries_ff, entries_in;
   logic [QPTR_W-1:0]               wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]               count_ff, count_in;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = entries_ff[rd_ptr_ff];

   // entry write, pointers and fill count
   always_comb begin
      entries_in = entries_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push) begin
         entries_in[wr_ptr_ff] = push_rec;
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // frame records
   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

endmodule

FILE: src/sbfr_back.sv
// ----------------------------------------------------------------------------
// sbfr_back
// result sequencer: one result per payload byte, or one error result
// ----------------------------------------------------------------------------
module sbfr_back
   import sbfr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          not_empty,
   input  frame_rec_type head,
   output logic          pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output byte_type      payload_byte,
   output logic [2:0]    payload_index,
   output byte_type      servo_id,
   output logic          frame_status,
   output logic          last_of_frame
);

   logic [2:0] k_ff, k_in;
   logic       xfer;

   assign rsp_tvalid    = not_empty;
   assign last_of_frame = k_ff == (head.count - 3'd1);
   assign frame_status  = head.status;
   assign servo_id      = head.id;
   assign payload_index = k_ff;
   assign payload_byte  = (head.status == STATUS_BAD) ? 8'h00 : head.payload[k_ff];

   assign xfer = rsp_tvalid && rsp_tready;
   assign pop  = xfer && last_of_frame;

   // result counter within the frame
   always_comb begin
      k_in = k_ff;
      if (xfer) begin
         k_in = last_of_frame ? 3'd0 : k_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else begin
         k_ff <= k_in;
      end
   end

endmodule

FILE: src/servo_bus_frame_receiver_core.sv
// a frame's first result is offered the cycle after its checksum byte if no earlier frame is queued
// throughput: one byte per cycle in; with rsp_tready high, one result per cycle out, back to back
// the parser stalls only on a checksum byte while both frame queue slots are occupied
// reset: synchronous, active high; clears hunt, frame and queue state, header 0x55, max length 7
// ----------------------------------------------------------------------------
// servo_bus_frame_receiver_core
// servo bus frame receiver: parser, frame queue and result sequencer
// ----------------------------------------------------------------------------
module servo_bus_frame_receiver_core
   import sbfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // received bytes
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] rx_byte
   // results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // [7:0] payload_byte, [10:8] payload_index,
                                              // [18:11] servo_id, [23:19] zero
   output logic                  rsp_tuser,   // [0] frame_status
   output logic                  rsp_tlast
);

   logic          push, pop, q_full, q_not_empty;
   frame_rec_type push_rec, head;
   byte_type      payload_byte, servo_id;
   logic [2:0]    payload_index;

   // parser
   sbfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rx_byte    (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .push_rec   (push_rec)
   );

   // frame queue
   sbfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   // result sequencer
   sbfr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .not_empty     (q_not_empty),
      .head          (head),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .payload_byte  (payload_byte),
      .payload_index (payload_index),
      .servo_id      (servo_id),
      .frame_status  (rsp_tuser),
      .last_of_frame (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, servo_id, payload_index, payload_byte};

endmodule
